>>> src/rrcm_pkg.sv
package rrcm_pkg;

    localparam int REGION_BYTES     = 4096;
    localparam int MAX_ACCESS_BYTES = 64;
    localparam int WORD_BITS        = 64;
    localparam int MASK_WORDS       = REGION_BYTES / WORD_BITS;
    localparam int CHUNK_BITS       = 8;

    localparam int ADDR_W  = 64;
    localparam int ID_W    = 32;
    localparam int CNT_W   = 32;
    localparam int BYTES_W = 7;
    localparam int OFS_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int WIDX_W  = 6;
    localparam int CFG_IDX_W = 2;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 136;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTER_OFFSET = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EVAL,
        ST_RD0,
        ST_WR0,
        ST_RD1,
        ST_WR1,
        ST_SCAN_RD,
        ST_SCAN_CH,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic accept;
        logic count_call;
        logic start;
        logic eval;
        logic mem_rd;
        logic word_sel;
        logic mem_wr;
        logic scan_init;
        logic scan_rd;
        logic scan_step;
        logic report;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       active;
        logic       mark_needed;
        logic       two_words;
        logic       scan_done;
        logic       scan_word_end;
        logic       out_free;
    } status_t;

endpackage

>>> src/region_read_coverage_monitor.sv
// Region read coverage monitor.
// Input stream (s_*): one request per transfer, kind in s_tuser (read, start, end).
// Output stream (m_*): one report per end request; m_tuser says a session was active.
// Configuration: cfg_we/cfg_index/cfg_data write region base, size and pointer offset;
// write only while the block is idle.
// Steps taken from one input transfer until the next one can be accepted:
//   start, reserved kind, read while inactive: accept, then dispatch
//   read while active: evaluate, then stop on a miss, mark one mask word, or mark
//   two when the access spans two words (read-modify-write through the mask RAM)
//   end: scan the mask, eight mask bits per cycle plus one RAM read per 64-bit word,
//   at least one of each for an empty region, then report
//   end while inactive: accept, dispatch, report.
// The report sits in an output register; while the receiver stalls, reads and starts
// keep flowing, and only a second end waits until the pending report is taken.
// Reset: mask empty, no session, counters zero, size 4096, base and pointer zero;
// no clearing pass is needed since each mask word carries a valid flag.
module region_read_coverage_monitor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rrcm_pkg::IN_TDATA_W-1:0]  s_tdata,   // access_address, access_bytes, session_id
    input  logic [1:0]                       s_tuser,   // req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // id_mismatch, max_distance, bytes_read_total, first_read_offset, last_read_offset,
    // bytes_read_from_pointer, read_calls, read_hits
    output logic [rrcm_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [0:0]                       m_tuser,   // session_was_active
    input  logic                             cfg_we,
    input  logic [rrcm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rrcm_pkg::ADDR_W-1:0]      cfg_data
);

    rrcm_pkg::cmd_t    cmd;
    rrcm_pkg::status_t status;

    rrcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rrcm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> src/rrcm_ctrl.sv
module rrcm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rrcm_pkg::status_t status,
    output rrcm_pkg::cmd_t    cmd
);

    rrcm_pkg::state_t state_reg;
    rrcm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrcm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            rrcm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = rrcm_pkg::ST_DISPATCH;
                end
            end
            rrcm_pkg::ST_DISPATCH:
            begin
                state_next = rrcm_pkg::ST_IDLE;
                unique case (status.req_type)
                    rrcm_pkg::REQ_READ:
                    begin
                        cmd.count_call = 1'b1;
                        if (status.active)
                        begin
                            state_next = rrcm_pkg::ST_EVAL;
                        end
                    end
                    rrcm_pkg::REQ_START:
                    begin
                        cmd.start = !status.active;
                    end
                    rrcm_pkg::REQ_END:
                    begin
                        if (status.active)
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = rrcm_pkg::ST_SCAN_RD;
                        end
                        else
                        begin
                            state_next = rrcm_pkg::ST_REPORT;
                        end
                    end
                    default:
                    begin
                        state_next = rrcm_pkg::ST_IDLE;
                    end
                endcase
            end
            rrcm_pkg::ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = rrcm_pkg::ST_RD0;
            end
            rrcm_pkg::ST_RD0:
            begin
                if (status.mark_needed)
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = rrcm_pkg::ST_WR0;
                end
                else
                begin
                    state_next = rrcm_pkg::ST_IDLE;
                end
            end
            rrcm_pkg::ST_WR0:
            begin
                cmd.mem_wr = 1'b1;
                state_next = status.two_words ? rrcm_pkg::ST_RD1 : rrcm_pkg::ST_IDLE;
            end
            rrcm_pkg::ST_RD1:
            begin
                cmd.mem_rd   = 1'b1;
                cmd.word_sel = 1'b1;
                state_next   = rrcm_pkg::ST_WR1;
            end
            rrcm_pkg::ST_WR1:
            begin
                cmd.mem_wr = 1'b1;
                state_next = rrcm_pkg::ST_IDLE;
            end
            rrcm_pkg::ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = rrcm_pkg::ST_SCAN_CH;
            end
            rrcm_pkg::ST_SCAN_CH:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = rrcm_pkg::ST_REPORT;
                end
                else if (status.scan_word_end)
                begin
                    state_next = rrcm_pkg::ST_SCAN_RD;
                end
            end
            rrcm_pkg::ST_REPORT:
            begin
                if (status.out_free)
                begin
                    cmd.report = 1'b1;
                    state_next = rrcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrcm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/rrcm_datapath.sv
module rrcm_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [rrcm_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rrcm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [0:0]                           m_tuser,
    input  logic                                 cfg_we,
    input  logic [rrcm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rrcm_pkg::ADDR_W-1:0]          cfg_data,
    input  rrcm_pkg::cmd_t                       cmd,
    output rrcm_pkg::status_t                    status
);

    // configuration
    logic [rrcm_pkg::ADDR_W-1:0] region_base_reg;
    logic [rrcm_pkg::SIZE_W-1:0] region_size_reg;
    logic [rrcm_pkg::OFS_W-1:0]  pointer_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg    <= '0;
            region_size_reg    <= rrcm_pkg::SIZE_RESET;
            pointer_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rrcm_pkg::CFG_REGION_BASE:    region_base_reg    <= cfg_data;
                rrcm_pkg::CFG_REGION_SIZE:    region_size_reg    <= cfg_data[rrcm_pkg::SIZE_W-1:0];
                rrcm_pkg::CFG_POINTER_OFFSET: pointer_offset_reg <= cfg_data[rrcm_pkg::OFS_W-1:0];
                default:                      region_base_reg    <= region_base_reg;
            endcase
        end
    end

    logic [rrcm_pkg::SIZE_W-1:0]  size_eff;
    logic [rrcm_pkg::BYTES_W-1:0] bytes_eff;

    assign size_eff = (region_size_reg > rrcm_pkg::SIZE_W'(rrcm_pkg::REGION_BYTES))
                    ? rrcm_pkg::SIZE_W'(rrcm_pkg::REGION_BYTES) : region_size_reg;

    // input item
    logic [1:0]                   type_reg;
    logic [rrcm_pkg::ADDR_W-1:0]  addr_reg;
    logic [rrcm_pkg::BYTES_W-1:0] bytes_reg;
    logic [rrcm_pkg::ID_W-1:0]    id_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            type_reg  <= s_tuser;
            addr_reg  <= s_tdata[63:0];
            bytes_reg <= s_tdata[70:64];
            id_reg    <= s_tdata[102:71];
        end
    end

    assign bytes_eff = (bytes_reg > rrcm_pkg::BYTES_W'(rrcm_pkg::MAX_ACCESS_BYTES))
                     ? rrcm_pkg::BYTES_W'(rrcm_pkg::MAX_ACCESS_BYTES) : bytes_reg;

    // address offset, bit 64 is the borrow (access below region base)
    logic [rrcm_pkg::ADDR_W:0] diff_reg;

    always_ff @(posedge clk)
    begin
        diff_reg <= {1'b0, addr_reg} - {1'b0, region_base_reg};
    end

    // overlap evaluation
    logic [rrcm_pkg::ADDR_W-1:0]  gap;
    logic [rrcm_pkg::SIZE_W-1:0]  hi_sum;
    logic [rrcm_pkg::SIZE_W-1:0]  hi_raw;
    logic                         hit_comb;
    logic [rrcm_pkg::OFS_W-1:0]   lo_comb;
    logic [rrcm_pkg::SIZE_W-1:0]  hi_comb;

    always_comb
    begin
        gap      = '0 - diff_reg[rrcm_pkg::ADDR_W-1:0];
        hi_sum   = {1'b0, diff_reg[rrcm_pkg::OFS_W-1:0]} + rrcm_pkg::SIZE_W'(bytes_eff);
        hit_comb = 1'b0;
        lo_comb  = '0;
        hi_raw   = '0;
        if (!diff_reg[rrcm_pkg::ADDR_W])
        begin
            lo_comb  = diff_reg[rrcm_pkg::OFS_W-1:0];
            hi_raw   = hi_sum;
            hit_comb = (diff_reg[rrcm_pkg::ADDR_W-1:rrcm_pkg::SIZE_W] == '0)
                    && (diff_reg[rrcm_pkg::SIZE_W-1:0] < size_eff)
                    && !((diff_reg[rrcm_pkg::ADDR_W-1:0] == '0) && (bytes_eff == '0));
        end
        else
        begin
            hi_raw   = rrcm_pkg::SIZE_W'(bytes_eff - gap[rrcm_pkg::BYTES_W-1:0]);
            hit_comb = (gap[rrcm_pkg::ADDR_W-1:rrcm_pkg::BYTES_W] == '0)
                    && (gap[rrcm_pkg::BYTES_W-1:0] < bytes_eff);
        end
        hi_comb = (hi_raw > size_eff) ? size_eff : hi_raw;
    end

    logic                        hit_reg;
    logic [rrcm_pkg::OFS_W-1:0]  lo_reg;
    logic [rrcm_pkg::SIZE_W-1:0] hi_reg;
    logic [rrcm_pkg::OFS_W-1:0]  hi_last;

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            hit_reg <= hit_comb;
            lo_reg  <= lo_comb;
            hi_reg  <= hi_comb;
        end
    end

    assign hi_last = hi_reg[rrcm_pkg::OFS_W-1:0] - 1'b1;

    // session state
    logic                      active_reg;
    logic [rrcm_pkg::ID_W-1:0] stored_id_reg;
    logic [rrcm_pkg::CNT_W-1:0] call_count_reg;
    logic [rrcm_pkg::CNT_W-1:0] hit_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            stored_id_reg  <= '0;
            call_count_reg <= '0;
            hit_count_reg  <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                active_reg     <= 1'b1;
                stored_id_reg  <= id_reg;
                call_count_reg <= '0;
                hit_count_reg  <= '0;
            end
            if (cmd.count_call)
            begin
                call_count_reg <= call_count_reg + 1'b1;
            end
            if (cmd.eval && hit_comb)
            begin
                hit_count_reg <= hit_count_reg + 1'b1;
            end
            if (cmd.report)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    // mask memory, one valid flag per word
    logic [rrcm_pkg::WORD_BITS-1:0]  mask_mem [rrcm_pkg::MASK_WORDS];
    logic [rrcm_pkg::MASK_WORDS-1:0] word_valid_reg;
    logic [rrcm_pkg::WORD_BITS-1:0]  rd_data_reg;
    logic                            rd_valid_reg;
    logic [rrcm_pkg::WIDX_W-1:0]     rmw_word_reg;
    logic [rrcm_pkg::WIDX_W-1:0]     rd_word;
    logic [rrcm_pkg::WORD_BITS-1:0]  range_bits;
    logic [rrcm_pkg::WORD_BITS-1:0]  wr_data;
    logic [rrcm_pkg::SIZE_W-1:0]     scan_idx_reg;

    always_comb
    begin
        if (cmd.scan_rd)
        begin
            rd_word = scan_idx_reg[rrcm_pkg::OFS_W-1:rrcm_pkg::OFS_W-rrcm_pkg::WIDX_W];
        end
        else if (cmd.word_sel)
        begin
            rd_word = hi_last[rrcm_pkg::OFS_W-1:rrcm_pkg::OFS_W-rrcm_pkg::WIDX_W];
        end
        else
        begin
            rd_word = lo_reg[rrcm_pkg::OFS_W-1:rrcm_pkg::OFS_W-rrcm_pkg::WIDX_W];
        end
    end

    always_comb
    begin
        for (int j = 0; j < rrcm_pkg::WORD_BITS; j++)
        begin
            range_bits[j] = ({1'b0, rmw_word_reg, 6'(j)} >= {1'b0, lo_reg})
                         && ({1'b0, rmw_word_reg, 6'(j)} < hi_reg);
        end
        wr_data = (rd_valid_reg ? rd_data_reg : '0) | range_bits;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mask_mem[rmw_word_reg] <= wr_data;
        end
        if (cmd.mem_rd || cmd.scan_rd)
        begin
            rd_data_reg  <= mask_mem[rd_word];
            rd_valid_reg <= word_valid_reg[rd_word];
            rmw_word_reg <= rd_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
        end
        else if (cmd.start)
        begin
            word_valid_reg <= '0;
        end
        else if (cmd.mem_wr)
        begin
            word_valid_reg[rmw_word_reg] <= 1'b1;
        end
    end

    // end-of-session scan, one byte of the mask per step
    logic [rrcm_pkg::SIZE_W-1:0]     tot_reg, tot_next;
    logic [rrcm_pkg::SIZE_W-1:0]     fp_reg, fp_next;
    logic [rrcm_pkg::SIZE_W-1:0]     first_reg, first_next;
    logic [rrcm_pkg::OFS_W-1:0]      last_reg, last_next;
    logic [rrcm_pkg::SIZE_W-1:0]     md_reg, md_next;
    logic                            found_reg, found_next;
    logic [rrcm_pkg::CHUNK_BITS-1:0] chunk;
    logic [rrcm_pkg::SIZE_W-1:0]     scan_pos;
    logic [rrcm_pkg::SIZE_W-1:0]     scan_idx_step;

    assign chunk = rd_valid_reg ? rd_data_reg[{scan_idx_reg[5:3], 3'b000} +: rrcm_pkg::CHUNK_BITS]
                                : '0;
    assign scan_idx_step = scan_idx_reg + rrcm_pkg::SIZE_W'(rrcm_pkg::CHUNK_BITS);

    always_comb
    begin
        tot_next   = tot_reg;
        fp_next    = fp_reg;
        first_next = first_reg;
        last_next  = last_reg;
        md_next    = md_reg;
        found_next = found_reg;
        scan_pos   = scan_idx_reg;
        for (int k = 0; k < rrcm_pkg::CHUNK_BITS; k++)
        begin
            scan_pos = scan_idx_reg + rrcm_pkg::SIZE_W'(k);
            if (chunk[k] && (scan_pos < size_eff))
            begin
                tot_next = tot_next + 1'b1;
                if (!found_next)
                begin
                    first_next = scan_pos;
                    found_next = 1'b1;
                end
                last_next = scan_pos[rrcm_pkg::OFS_W-1:0];
                if (scan_pos >= {1'b0, pointer_offset_reg})
                begin
                    fp_next = fp_next + 1'b1;
                    md_next = scan_pos - {1'b0, pointer_offset_reg} + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_init)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            tot_reg   <= '0;
            fp_reg    <= '0;
            first_reg <= size_eff;
            last_reg  <= '0;
            md_reg    <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            tot_reg   <= tot_next;
            fp_reg    <= fp_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            md_reg    <= md_next;
            found_reg <= found_next;
        end
    end

    // output register
    logic                             out_valid_reg;
    logic [rrcm_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                             out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.report)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            out_user_reg <= active_reg;
            if (active_reg)
            begin
                out_data_reg <= {7'd0, hit_count_reg, call_count_reg, fp_reg, last_reg,
                                 first_reg, tot_reg, md_reg, (stored_id_reg != id_reg)};
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;

    assign status.req_type      = type_reg;
    assign status.active        = active_reg;
    assign status.mark_needed   = hit_reg && (hi_reg > {1'b0, lo_reg});
    assign status.two_words     = hi_last[rrcm_pkg::OFS_W-1:rrcm_pkg::OFS_W-rrcm_pkg::WIDX_W]
                               != lo_reg[rrcm_pkg::OFS_W-1:rrcm_pkg::OFS_W-rrcm_pkg::WIDX_W];
    assign status.scan_done     = scan_idx_step >= size_eff;
    assign status.scan_word_end = scan_idx_reg[5:3] == 3'd7;
    assign status.out_free      = !out_valid_reg || m_tready;

endmodule

>>> src/rrcm_checker.sv
module rrcm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rrcm_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [0:0]                       m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("report changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after an input transfer");

    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("report without session is not all zero");

    a_ptr_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[64:52] <= m_tdata[26:14]))
        else $error("bytes from pointer exceed total");

    a_first_le_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[26:14] != '0)) |-> (m_tdata[39:27] <= {1'b0, m_tdata[51:40]}))
        else $error("first offset above last offset");

endmodule

bind region_read_coverage_monitor rrcm_checker u_rrcm_checker (.*);
